// File: sv/ufstf_pkg.sv
// shared types and constants for the union-find spanning tree filter
// no dependencies; imported by ufstf_ctrl, ufstf_dp and the top level
package ufstf_pkg;

	localparam int MAX_NODES = 65536;
	localparam int NODE_W    = 16;
	localparam int CNT_W     = 17;
	localparam int SIZE_W    = 17;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_FIND,
		S_COMP,
		S_JOIN,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_LOAD,
		OP_WALK,
		OP_COMPRESS,
		OP_JOIN
	} dp_op_t;

	typedef struct packed {
		logic clr_last;
		logic reject;
		logic at_root;
		logic on_root;
		logic side;
	} dp_stat_t;

endpackage

// File: sv/ufstf_ram.sv
// generic simple dual-port ram, one write and one registered read a cycle
// no package dependencies
module ufstf_ram #(
	parameter int ADDR_W = 16,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [(2**ADDR_W)-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/ufstf_ctrl.sv
// controller state machine: clearing pass, root walks, compression, join
// depends on ufstf_pkg
module ufstf_ctrl import ufstf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_op_t   op,
	output logic     busy,
	output logic     done
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_d = S_FIND;
			end
			S_FIND: begin
				if (stat.reject) state_d = S_DONE;
				else if (stat.at_root) state_d = S_COMP;
			end
			S_COMP: begin
				if (stat.on_root) state_d = stat.side ? S_JOIN : S_FIND;
			end
			S_JOIN: state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		op   = OP_NONE;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			S_CLEAR: op = OP_CLEAR;
			S_IDLE: begin
				busy = 1'b0;
				if (start) op = OP_LOAD;
			end
			S_FIND: begin
				if (!stat.reject) op = OP_WALK;
			end
			S_COMP: op = OP_COMPRESS;
			S_JOIN: op = OP_JOIN;
			S_DONE: done = 1'b1;
			default: op = OP_NONE;
		endcase
	end

endmodule

// File: sv/ufstf_dp.sv
// datapath: parent and size memories, walk registers, counters and node count
// depends on ufstf_pkg and ufstf_ram
module ufstf_dp import ufstf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_op_t            op,
	output dp_stat_t          stat,
	input  logic [NODE_W-1:0] from_node,
	input  logic [NODE_W-1:0] to_node,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_data,
	output logic              accepted,
	output logic              tree_complete,
	output logic              index_error,
	output logic [NODE_W-1:0] tree_edges
);

	logic [CNT_W-1:0]  node_count_q;
	logic [NODE_W-1:0] clr_q;
	logic [NODE_W-1:0] count_q;
	logic [NODE_W-1:0] a_q, b_q, cur_q, root_q, ra_q, rb_q;
	logic              side_q;
	logic [SIZE_W-1:0] size_a_q;
	logic              acc_q, err_q;

	logic [CNT_W-1:0]  n_eff, n_m1;
	logic              in_err, full;
	logic [NODE_W-1:0] start_node, win, lose;
	logic              a_small;
	logic [SIZE_W-1:0] size_sum;

	logic              pwe;
	logic [NODE_W-1:0] pwaddr, pwdata, praddr, prdata;
	logic              swe, sre;
	logic [NODE_W-1:0] swaddr, sraddr;
	logic [SIZE_W-1:0] swdata, srdata;

	ufstf_ram #(.ADDR_W(NODE_W), .DATA_W(NODE_W)) u_parent (
		.clk   (clk),
		.we    (pwe),
		.waddr (pwaddr),
		.wdata (pwdata),
		.re    (1'b1),
		.raddr (praddr),
		.rdata (prdata)
	);

	ufstf_ram #(.ADDR_W(NODE_W), .DATA_W(SIZE_W)) u_size (
		.clk   (clk),
		.we    (swe),
		.waddr (swaddr),
		.wdata (swdata),
		.re    (sre),
		.raddr (sraddr),
		.rdata (srdata)
	);

	// effective node count, clamped to one..MAX_NODES
	always_comb begin
		if (node_count_q == '0) n_eff = CNT_W'(1);
		else if (node_count_q > CNT_W'(MAX_NODES)) n_eff = CNT_W'(MAX_NODES);
		else n_eff = node_count_q;
	end

	assign n_m1       = n_eff - CNT_W'(1);
	assign in_err     = ({1'b0, from_node} >= n_eff) || ({1'b0, to_node} >= n_eff);
	assign full       = {1'b0, count_q} >= n_m1;
	assign start_node = side_q ? b_q : a_q;
	assign a_small    = size_a_q < srdata;
	assign win        = a_small ? rb_q : ra_q;
	assign lose       = a_small ? ra_q : rb_q;
	assign size_sum   = size_a_q + srdata;

	assign stat.clr_last = clr_q == '1;
	assign stat.reject   = err_q || full;
	assign stat.at_root  = prdata == cur_q;
	assign stat.on_root  = prdata == root_q;
	assign stat.side     = side_q;

	always_comb begin
		pwe    = 1'b0;
		pwaddr = cur_q;
		pwdata = root_q;
		praddr = cur_q;
		swe    = 1'b0;
		swaddr = win;
		swdata = size_sum;
		sre    = 1'b0;
		sraddr = root_q;
		unique case (op)
			OP_CLEAR: begin
				pwe    = 1'b1;
				pwaddr = clr_q;
				pwdata = clr_q;
				swe    = 1'b1;
				swaddr = clr_q;
				swdata = SIZE_W'(1);
			end
			OP_LOAD: praddr = from_node;
			OP_WALK: praddr = stat.at_root ? start_node : prdata;
			OP_COMPRESS: begin
				if (!stat.on_root) begin
					pwe    = 1'b1;
					praddr = prdata;
				end else begin
					// root size read stays in the read register until the join
					sre = 1'b1;
					if (!side_q) praddr = b_q;
				end
			end
			OP_JOIN: begin
				if (ra_q != rb_q) begin
					pwe    = 1'b1;
					pwaddr = lose;
					pwdata = win;
					swe    = 1'b1;
				end
			end
			default: pwe = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(MAX_NODES);
			clr_q        <= '0;
			count_q      <= '0;
			acc_q        <= 1'b0;
			err_q        <= 1'b0;
		end else begin
			if (cfg_we) node_count_q <= cfg_data;
			unique case (op)
				OP_CLEAR: clr_q <= clr_q + NODE_W'(1);
				OP_LOAD: begin
					acc_q <= 1'b0;
					err_q <= in_err;
				end
				OP_JOIN: begin
					if (ra_q != rb_q) begin
						acc_q   <= 1'b1;
						count_q <= count_q + NODE_W'(1);
					end
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				a_q    <= from_node;
				b_q    <= to_node;
				cur_q  <= from_node;
				side_q <= 1'b0;
			end
			OP_WALK: begin
				if (stat.at_root) begin
					root_q <= cur_q;
					cur_q  <= start_node;
				end else begin
					cur_q <= prdata;
				end
			end
			OP_COMPRESS: begin
				if (!stat.on_root) begin
					cur_q <= prdata;
				end else if (!side_q) begin
					ra_q   <= root_q;
					side_q <= 1'b1;
					cur_q  <= b_q;
				end else begin
					rb_q     <= root_q;
					size_a_q <= srdata;
				end
			end
			default: cur_q <= cur_q;
		endcase
	end

	assign accepted      = acc_q;
	assign index_error   = err_q;
	assign tree_complete = full;
	assign tree_edges    = count_q;

endmodule

// File: sv/union_find_spanning_tree_filter.sv
// per edge: after start, the walk runs from each endpoint up to its root, compressing
// the path on the way, and then the two roots are joined, the larger tree winning;
// a flagged edge or a full tree skips the walks and gives done directly; next start
// is taken the cycle after done, and no new edge is taken while busy is high
// reset: a clearing pass with busy high rewrites every entry of both tables;
// node_count is writable throughout, results cannot be stalled by the receiver
module union_find_spanning_tree_filter import ufstf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [NODE_W-1:0] from_node,
	input  logic [NODE_W-1:0] to_node,
	output logic              done,
	output logic              accepted,
	output logic              tree_complete,
	output logic              index_error,
	output logic [NODE_W-1:0] tree_edges,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data
);

	dp_op_t   op;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	ufstf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.op     (op),
		.busy   (busy),
		.done   (done)
	);

	ufstf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.stat          (stat),
		.from_node     (from_node),
		.to_node       (to_node),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.accepted      (accepted),
		.tree_complete (tree_complete),
		.index_error   (index_error),
		.tree_edges    (tree_edges)
	);

endmodule

// File: sv/ufstf_chk.sv
// port-level checker for the spanning tree filter, bound to the top level
// no package dependencies
module ufstf_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic accepted,
	input logic index_error
);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an item was taken");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("done not a single pulse followed by idle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done while idle");

	a_err_rejects: assert property (@(posedge clk) disable iff (!arst_n)
		done && index_error |-> !accepted)
		else $error("flagged edge accepted");

endmodule

bind union_find_spanning_tree_filter ufstf_chk u_chk (.*);
